>>> hw/rtl/ltc_pkg.sv
// Shared types and constants for the two-level LRU cache timing block.
// Used by every module under hw/rtl but ltc_ram; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
package ltc_pkg;

    localparam int ADDR_W = 32;

    localparam int L1I_SET_BITS_DEF = 7;
    localparam int L1D_SET_BITS_DEF = 7;
    localparam int L2_SET_BITS_DEF  = 9;
    localparam int L1I_MAX_WAYS_DEF = 4;
    localparam int L1D_MAX_WAYS_DEF = 4;
    localparam int L2_MAX_WAYS_DEF  = 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int LAT_W       = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_L1I_WAYS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_L1D_WAYS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_WAYS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_L1I_HIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_L1D_HIT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_HIT      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_LAT     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 3'd7;

    localparam logic [7:0] RST_L1I_HIT     = 8'd1;
    localparam logic [7:0] RST_L1D_HIT     = 8'd1;
    localparam logic [7:0] RST_L2_HIT      = 8'd10;
    localparam logic [9:0] RST_MEM_LAT     = 10'd100;
    localparam logic [2:0] RST_OFFSET_BITS = 3'd6;

    typedef struct packed {
        logic [2:0] l1i_ways;
        logic [2:0] l1d_ways;
        logic [3:0] l2_ways;
        logic [7:0] l1i_hit_time;
        logic [7:0] l1d_hit_time;
        logic [7:0] l2_hit_time;
        logic [9:0] mem_latency;
        logic [2:0] offset_bits;
    } t_cfg;

    typedef struct packed {
        logic              mode;
        logic              l1_hit;
        logic [ADDR_W-1:0] addr;
    } t_q_entry;

    typedef struct packed {
        logic done;
        logic hit;
    } t_look_rsp;

endpackage
`default_nettype wire

>>> hw/rtl/ltc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the set rows of every cache.
`timescale 1ns / 1ps
`default_nettype none
module ltc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> hw/rtl/ltc_cache_unit.sv
// One set-associative LRU tag cache: set row RAM, lookup, LRU update and fill.
// Depends on ltc_pkg and ltc_ram. A lookup reads the set row, then writes the row back.
`timescale 1ns / 1ps
`default_nettype none
module ltc_cache_unit #(
    parameter int SET_BITS = 7,
    parameter int MAX_WAYS = 4
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_req,
    input  wire logic [ltc_pkg::ADDR_W-1:0] i_addr,
    input  wire logic [3:0]                i_ways,
    input  wire logic [2:0]                i_offset,
    output logic                           o_ready,
    output ltc_pkg::t_look_rsp             o_rsp
);

    localparam int SETS    = 1 << SET_BITS;
    localparam int IDXW    = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int TAGW    = ltc_pkg::ADDR_W - SET_BITS;
    localparam int RANKW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int FILLW   = $clog2(MAX_WAYS + 1);
    localparam int TAG_LO  = FILLW;
    localparam int RANK_LO = FILLW + MAX_WAYS * TAGW;
    localparam int ROWW    = RANK_LO + MAX_WAYS * RANKW;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_LOOK  = 2'd2;

    logic [1:0]      r_st, n_st;
    logic [IDXW-1:0] r_clr_idx, n_clr_idx;
    logic [IDXW-1:0] r_set;
    logic [TAGW-1:0] r_tag;
    logic [FILLW-1:0] r_ways;

    logic [ltc_pkg::ADDR_W-1:0] w_sh;
    logic [IDXW-1:0]  w_set;
    logic [TAGW-1:0]  w_tag;
    logic [FILLW-1:0] w_ways;

    logic [ROWW-1:0] w_rdata, w_row;
    logic            w_we;
    logic [IDXW-1:0] w_waddr;
    logic            w_hit;

    assign w_sh  = i_addr >> i_offset;
    assign w_set = w_sh[IDXW-1:0] & IDXW'(SETS - 1);
    assign w_tag = TAGW'(w_sh >> SET_BITS);

    always_comb begin
        if (i_ways == 4'd0) begin
            w_ways = FILLW'(1);
        end else if (int'(i_ways) > MAX_WAYS) begin
            w_ways = FILLW'(MAX_WAYS);
        end else begin
            w_ways = FILLW'(i_ways);
        end
    end

    // Lookup on the row read in the previous cycle, and the row written back.
    always_comb begin
        logic [FILLW-1:0]                fill, nf;
        logic [MAX_WAYS-1:0][TAGW-1:0]   tg, nt;
        logic [MAX_WAYS-1:0][RANKW-1:0]  rk, nr;
        logic [RANKW-1:0]                hw, victim;
        logic                            hit;
        fill   = w_rdata[FILLW-1:0];
        tg     = w_rdata[RANK_LO-1:TAG_LO];
        rk     = w_rdata[ROWW-1:RANK_LO];
        nt     = tg;
        nr     = rk;
        nf     = fill;
        hit    = 1'b0;
        hw     = '0;
        victim = '0;
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (!hit && (i < int'(fill)) && (tg[i] == r_tag)) begin
                hit = 1'b1;
                hw  = RANKW'(i);
            end
        end
        if (hit) begin
            for (int j = 0; j < MAX_WAYS; j++) begin
                if ((j < int'(fill)) && (rk[j] < rk[hw])) begin
                    nr[j] = rk[j] + 1'b1;
                end
            end
            nr[hw] = '0;
        end else begin
            if (fill < r_ways) begin
                victim = RANKW'(fill);
                for (int i = 0; i < MAX_WAYS; i++) begin
                    if (i < int'(fill)) begin
                        nr[i] = rk[i] + 1'b1;
                    end
                end
                nf = fill + 1'b1;
            end else begin
                for (int i = 1; i < MAX_WAYS; i++) begin
                    if ((i < int'(fill)) && (rk[i] > rk[victim])) begin
                        victim = RANKW'(i);
                    end
                end
                for (int i = 0; i < MAX_WAYS; i++) begin
                    if ((i < int'(fill)) && (RANKW'(i) != victim)) begin
                        nr[i] = rk[i] + 1'b1;
                    end
                end
            end
            nt[victim] = r_tag;
            nr[victim] = '0;
        end
        w_hit = hit;
        w_row = {nr, nt, nf};
    end

    always_comb begin
        n_st      = r_st;
        n_clr_idx = r_clr_idx;
        case (r_st)
            S_CLEAR: begin
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == IDXW'(SETS - 1)) begin
                    n_st = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req) begin
                    n_st = S_LOOK;
                end
            end
            S_LOOK: begin
                n_st = S_IDLE;
            end
            default: begin
                n_st = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= S_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_st      <= n_st;
            r_clr_idx <= n_clr_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_IDLE && i_req) begin
            r_set  <= w_set;
            r_tag  <= w_tag;
            r_ways <= w_ways;
        end
    end

    assign w_we    = (r_st == S_CLEAR) || (r_st == S_LOOK);
    assign w_waddr = (r_st == S_CLEAR) ? r_clr_idx : r_set;

    ltc_ram #(
        .WIDTH(ROWW),
        .DEPTH(SETS)
    ) u_rows (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata((r_st == S_CLEAR) ? '0 : w_row),
        .i_raddr(w_set),
        .o_rdata(w_rdata)
    );

    assign o_ready  = (r_st == S_IDLE);
    assign o_rsp.done = (r_st == S_LOOK);
    assign o_rsp.hit  = w_hit;

endmodule
`default_nettype wire

>>> hw/rtl/ltc_queue.sv
// Short in-order queue of L1 outcomes between the front and back parts.
// Depends on ltc_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none
module ltc_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  ltc_pkg::t_q_entry      i_entry,
    input  wire logic              i_pop,
    output logic                   o_full,
    output logic                   o_valid,
    output ltc_pkg::t_q_entry      o_entry
);

    localparam int PW = (ltc_pkg::QUEUE_DEPTH > 1) ? $clog2(ltc_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(ltc_pkg::QUEUE_DEPTH + 1);

    ltc_pkg::t_q_entry r_slots [ltc_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(ltc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(ltc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wp] <= i_entry;
        end
    end

    assign o_full  = (r_cnt == CW'(ltc_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_slots[r_rp];

endmodule
`default_nettype wire

>>> hw/rtl/ltc_front.sv
// Front part: takes requests, looks them up in L1I or L1D and queues the outcome.
// Depends on ltc_pkg and ltc_cache_unit.
`timescale 1ns / 1ps
`default_nettype none
module ltc_front #(
    parameter int L1I_SET_BITS = ltc_pkg::L1I_SET_BITS_DEF,
    parameter int L1D_SET_BITS = ltc_pkg::L1D_SET_BITS_DEF,
    parameter int L1I_MAX_WAYS = ltc_pkg::L1I_MAX_WAYS_DEF,
    parameter int L1D_MAX_WAYS = ltc_pkg::L1D_MAX_WAYS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  ltc_pkg::t_cfg                   i_cfg,
    input  wire logic                       i_valid,
    input  wire logic                       i_mode,
    input  wire logic [ltc_pkg::ADDR_W-1:0] i_addr,
    output logic                            o_ready,
    input  wire logic                       i_q_full,
    output logic                            o_push,
    output ltc_pkg::t_q_entry               o_entry
);

    logic r_busy;
    logic r_mode;
    logic [ltc_pkg::ADDR_W-1:0] r_addr;
    logic w_acc;
    logic w_i_ready, w_d_ready;
    ltc_pkg::t_look_rsp w_i_rsp, w_d_rsp;
    ltc_pkg::t_look_rsp w_rsp;

    assign o_ready = !r_busy && w_i_ready && w_d_ready && !i_q_full;
    assign w_acc   = i_valid && o_ready;
    assign w_rsp   = r_mode ? w_d_rsp : w_i_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_acc) begin
            r_busy <= 1'b1;
        end else if (w_rsp.done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_mode <= i_mode;
            r_addr <= i_addr;
        end
    end

    ltc_cache_unit #(
        .SET_BITS(L1I_SET_BITS),
        .MAX_WAYS(L1I_MAX_WAYS)
    ) u_l1i (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_acc && !i_mode),
        .i_addr  (i_addr),
        .i_ways  ({1'b0, i_cfg.l1i_ways}),
        .i_offset(i_cfg.offset_bits),
        .o_ready (w_i_ready),
        .o_rsp   (w_i_rsp)
    );

    ltc_cache_unit #(
        .SET_BITS(L1D_SET_BITS),
        .MAX_WAYS(L1D_MAX_WAYS)
    ) u_l1d (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_acc && i_mode),
        .i_addr  (i_addr),
        .i_ways  ({1'b0, i_cfg.l1d_ways}),
        .i_offset(i_cfg.offset_bits),
        .o_ready (w_d_ready),
        .o_rsp   (w_d_rsp)
    );

    assign o_push         = r_busy && w_rsp.done;
    assign o_entry.mode   = r_mode;
    assign o_entry.l1_hit = w_rsp.hit;
    assign o_entry.addr   = r_addr;

endmodule
`default_nettype wire

>>> hw/rtl/ltc_back.sv
// Back part: takes queued L1 outcomes, looks L1 misses up in the L2 and
// builds the latency and hit flags. Depends on ltc_pkg and ltc_cache_unit.
`timescale 1ns / 1ps
`default_nettype none
module ltc_back #(
    parameter int L2_SET_BITS = ltc_pkg::L2_SET_BITS_DEF,
    parameter int L2_MAX_WAYS = ltc_pkg::L2_MAX_WAYS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  ltc_pkg::t_cfg                  i_cfg,
    input  wire logic                      i_q_valid,
    input  ltc_pkg::t_q_entry              i_q_entry,
    output logic                           o_pop,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [ltc_pkg::LAT_W-1:0]      o_latency,
    output logic                           o_l1_hit,
    output logic                           o_l2_accessed,
    output logic                           o_l2_hit
);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_REQ  = 2'd1;
    localparam logic [1:0] B_WAIT = 2'd2;

    logic [1:0] r_st;
    ltc_pkg::t_q_entry r_entry;
    logic w_l2_ready, w_l2_req;
    ltc_pkg::t_look_rsp w_l2_rsp;
    logic [ltc_pkg::LAT_W-1:0] w_l1_time, w_miss_lat;

    assign o_pop    = (r_st == B_IDLE) && i_q_valid && !o_valid;
    assign w_l2_req = (r_st == B_REQ) && w_l2_ready;

    assign w_l1_time = r_entry.mode ? ltc_pkg::LAT_W'(i_cfg.l1d_hit_time)
                                    : ltc_pkg::LAT_W'(i_cfg.l1i_hit_time);
    assign w_miss_lat = w_l1_time + ltc_pkg::LAT_W'(i_cfg.l2_hit_time)
                      + (w_l2_rsp.hit ? '0 : ltc_pkg::LAT_W'(i_cfg.mem_latency));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= B_IDLE;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            case (r_st)
                B_IDLE: begin
                    if (o_pop) begin
                        if (i_q_entry.l1_hit) begin
                            o_valid <= 1'b1;
                        end else begin
                            r_st <= B_REQ;
                        end
                    end
                end
                B_REQ: begin
                    if (w_l2_ready) begin
                        r_st <= B_WAIT;
                    end
                end
                B_WAIT: begin
                    if (w_l2_rsp.done) begin
                        o_valid <= 1'b1;
                        r_st    <= B_IDLE;
                    end
                end
                default: begin
                    r_st <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_entry <= i_q_entry;
            if (i_q_entry.l1_hit) begin
                o_latency     <= i_q_entry.mode ? ltc_pkg::LAT_W'(i_cfg.l1d_hit_time)
                                                : ltc_pkg::LAT_W'(i_cfg.l1i_hit_time);
                o_l1_hit      <= 1'b1;
                o_l2_accessed <= 1'b0;
                o_l2_hit      <= 1'b0;
            end
        end else if (r_st == B_WAIT && w_l2_rsp.done) begin
            o_latency     <= w_miss_lat;
            o_l1_hit      <= 1'b0;
            o_l2_accessed <= 1'b1;
            o_l2_hit      <= w_l2_rsp.hit;
        end
    end

    ltc_cache_unit #(
        .SET_BITS(L2_SET_BITS),
        .MAX_WAYS(L2_MAX_WAYS)
    ) u_l2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_l2_req),
        .i_addr  (r_entry.addr),
        .i_ways  (i_cfg.l2_ways),
        .i_offset(i_cfg.offset_bits),
        .o_ready (w_l2_ready),
        .o_rsp   (w_l2_rsp)
    );

endmodule
`default_nettype wire

>>> hw/rtl/two_level_lru_cache_timing_top.sv
// Top level: configuration registers, front (L1 lookup), queue and back (L2).
// Depends on ltc_pkg, ltc_front, ltc_queue and ltc_back.
//
//  Channel   Direction  tdata                       tuser
//  s_axis    in         [31:0] address              [0] mode
//  m_axis    out        [10:0] latency, zero pad    [0] l1_hit [1] l2_accessed [2] l2_hit
//  cfg       in         i_cfg_index / i_cfg_data, written when i_cfg_we is high
//
// An L1 lookup reads the set row, then writes back to the same row RAM, and the
// front takes no new request until that lookup is done. An L1 miss adds an L2 lookup
// in the back part, which overlaps the next L1 lookup. A result waits in the output
// register; the back part takes the next queued item the cycle after it is taken.
// After reset each cache clears its row RAM, one set a cycle; the L2 has
// 2^L2_SET_BITS sets (512 by default) and no request is taken until the L1s are clear.
// A stalled output holds the back part; the front keeps going until the queue is full.
`timescale 1ns / 1ps
`default_nettype none
module two_level_lru_cache_timing_top #(
    parameter int L1I_SET_BITS = ltc_pkg::L1I_SET_BITS_DEF,
    parameter int L1D_SET_BITS = ltc_pkg::L1D_SET_BITS_DEF,
    parameter int L2_SET_BITS  = ltc_pkg::L2_SET_BITS_DEF,
    parameter int L1I_MAX_WAYS = ltc_pkg::L1I_MAX_WAYS_DEF,
    parameter int L1D_MAX_WAYS = ltc_pkg::L1D_MAX_WAYS_DEF,
    parameter int L2_MAX_WAYS  = ltc_pkg::L2_MAX_WAYS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [31:0]                   s_axis_tdata,  // [31:0] address
    input  wire logic [0:0]                    s_axis_tuser,  // [0] mode
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [15:0]                        m_axis_tdata,  // [10:0] latency
    output logic [2:0]                         m_axis_tuser,  // [0] l1_hit [1] l2_accessed [2] l2_hit
    input  wire logic                          i_cfg_we,
    input  wire logic [ltc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ltc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [2:0] RST_L1I_WAYS = 3'((L1I_MAX_WAYS < 4) ? L1I_MAX_WAYS : 4);
    localparam logic [2:0] RST_L1D_WAYS = 3'((L1D_MAX_WAYS < 4) ? L1D_MAX_WAYS : 4);
    localparam logic [3:0] RST_L2_WAYS  = 4'((L2_MAX_WAYS < 8) ? L2_MAX_WAYS : 8);

    ltc_pkg::t_cfg r_cfg;
    logic w_push, w_pop, w_q_full, w_q_valid;
    ltc_pkg::t_q_entry w_push_entry, w_head;
    logic [ltc_pkg::LAT_W-1:0] w_latency;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.l1i_ways     <= RST_L1I_WAYS;
            r_cfg.l1d_ways     <= RST_L1D_WAYS;
            r_cfg.l2_ways      <= RST_L2_WAYS;
            r_cfg.l1i_hit_time <= ltc_pkg::RST_L1I_HIT;
            r_cfg.l1d_hit_time <= ltc_pkg::RST_L1D_HIT;
            r_cfg.l2_hit_time  <= ltc_pkg::RST_L2_HIT;
            r_cfg.mem_latency  <= ltc_pkg::RST_MEM_LAT;
            r_cfg.offset_bits  <= ltc_pkg::RST_OFFSET_BITS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ltc_pkg::CFG_L1I_WAYS:    r_cfg.l1i_ways     <= i_cfg_data[2:0];
                ltc_pkg::CFG_L1D_WAYS:    r_cfg.l1d_ways     <= i_cfg_data[2:0];
                ltc_pkg::CFG_L2_WAYS:     r_cfg.l2_ways      <= i_cfg_data[3:0];
                ltc_pkg::CFG_L1I_HIT:     r_cfg.l1i_hit_time <= i_cfg_data[7:0];
                ltc_pkg::CFG_L1D_HIT:     r_cfg.l1d_hit_time <= i_cfg_data[7:0];
                ltc_pkg::CFG_L2_HIT:      r_cfg.l2_hit_time  <= i_cfg_data[7:0];
                ltc_pkg::CFG_MEM_LAT:     r_cfg.mem_latency  <= i_cfg_data[9:0];
                ltc_pkg::CFG_OFFSET_BITS: r_cfg.offset_bits  <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    ltc_front #(
        .L1I_SET_BITS(L1I_SET_BITS),
        .L1D_SET_BITS(L1D_SET_BITS),
        .L1I_MAX_WAYS(L1I_MAX_WAYS),
        .L1D_MAX_WAYS(L1D_MAX_WAYS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .i_mode  (s_axis_tuser[0]),
        .i_addr  (s_axis_tdata),
        .o_ready (s_axis_tready),
        .i_q_full(w_q_full),
        .o_push  (w_push),
        .o_entry (w_push_entry)
    );

    ltc_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_entry(w_push_entry),
        .i_pop  (w_pop),
        .o_full (w_q_full),
        .o_valid(w_q_valid),
        .o_entry(w_head)
    );

    ltc_back #(
        .L2_SET_BITS(L2_SET_BITS),
        .L2_MAX_WAYS(L2_MAX_WAYS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_valid    (w_q_valid),
        .i_q_entry    (w_head),
        .o_pop        (w_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_latency    (w_latency),
        .o_l1_hit     (m_axis_tuser[0]),
        .o_l2_accessed(m_axis_tuser[1]),
        .o_l2_hit     (m_axis_tuser[2])
    );

    assign m_axis_tdata = {5'd0, w_latency};

endmodule
`default_nettype wire
